// ===== hw/rtl/assert_macros.svh =====
// assertion macros of the lookup cache, used by its top level
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tlc_pkg.sv =====
// types, sizes and codes of the ttl lookup cache
// used by tlc_expiry and ttl_lookup_cache; no dependencies
`default_nettype none

package tlc_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int COUNT_W = $clog2(ENTRIES + 1);

	localparam int KEY_W  = 64;
	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int TTL_W  = 16;
	localparam int SLOT_W = 3;

	localparam logic [TTL_W-1:0]   TTL_RESET  = 16'd10;
	localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(ENTRIES - 1);
	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(ENTRIES);

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	typedef enum logic [1:0] {
		STAT_FRESH   = 2'd0,
		STAT_EXPIRED = 2'd1,
		STAT_MISS    = 2'd2,
		STAT_FILL    = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] created;
	} entry_t;

	// low bits of an entry index as reported on slot_index
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlc_expiry.sv =====
// age check of one entry: (now - created) mod 2^32 against the lifetime
// depends on tlc_pkg
`default_nettype none

module tlc_expiry (
	input  wire logic [tlc_pkg::TIME_W-1:0] now_seconds,
	input  wire logic [tlc_pkg::TIME_W-1:0] created,
	input  wire logic [tlc_pkg::TTL_W-1:0]  ttl_seconds,
	output logic                            expired
);

	logic [tlc_pkg::TIME_W-1:0] age;

	// wraps, so a clock running backwards gives a large age
	assign age     = now_seconds - created;
	assign expired = age > {{(tlc_pkg::TIME_W - tlc_pkg::TTL_W){1'b0}}, ttl_seconds};

endmodule

`default_nettype wire

// ===== hw/rtl/ttl_lookup_cache.sv =====
// key-to-address cache with lifetime expiry, top level
// depends on tlc_pkg, tlc_expiry and assert_macros.svh
`default_nettype none

// An item is taken when start is high and busy is low. It walks the filled
// entries from slot 0 upward, one entry per cycle through the single read port
// of the entry memory; busy stays high until the walk ends at the first
// matching slot, or at the last filled slot on no match (at once when the
// table is empty). The result shows on the output ports for exactly one
// cycle with done high, the cycle after the walk ends, and must be taken
// then; the next item can be started in that same cycle. The ttl register
// is always ready and should only be written while no item is in progress.
// No clearing pass after reset.
module ttl_lookup_cache (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            operation,
	input  wire logic [tlc_pkg::KEY_W-1:0]       lookup_key,
	input  wire logic [tlc_pkg::ADDR_W-1:0]      fill_address,
	input  wire logic [tlc_pkg::TIME_W-1:0]      now_seconds,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [tlc_pkg::ADDR_W-1:0]           stored_address,
	output logic [tlc_pkg::SLOT_W-1:0]           slot_index,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tlc_pkg::TTL_W-1:0]       cfg_data
);

	tlc_pkg::state_t state_q, state_d;

	logic [tlc_pkg::TTL_W-1:0]   ttl_q;
	logic [tlc_pkg::COUNT_W-1:0] count_q;
	logic [tlc_pkg::IDX_W-1:0]   idx_q;
	logic                        exp_found_q;
	logic [tlc_pkg::IDX_W-1:0]   exp_idx_q;

	logic                        op_q;
	logic [tlc_pkg::KEY_W-1:0]   key_q;
	logic [tlc_pkg::ADDR_W-1:0]  fill_q;
	logic [tlc_pkg::TIME_W-1:0]  now_q;

	logic                        done_q;
	tlc_pkg::status_t            status_q;
	logic [tlc_pkg::ADDR_W-1:0]  address_q;
	logic [tlc_pkg::SLOT_W-1:0]  slot_q;

	tlc_pkg::entry_t mem [tlc_pkg::ENTRIES];
	tlc_pkg::entry_t rd_q;
	tlc_pkg::entry_t wr_data;
	logic [tlc_pkg::IDX_W-1:0]   rd_idx;
	logic [tlc_pkg::IDX_W-1:0]   wr_idx;
	logic                        mem_we;

	logic accept;
	logic count_nz;
	logic hit;
	logic last;
	logic finish;
	logic cur_exp;
	logic entry_exp;
	logic append;
	logic [tlc_pkg::IDX_W-1:0] victim_idx;

	assign accept    = start && !busy;
	assign busy      = (state_q != tlc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	tlc_expiry u_expiry (
		.now_seconds (now_q),
		.created     (rd_q.created),
		.ttl_seconds (ttl_q),
		.expired     (entry_exp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tlc_pkg::ST_SCAN;
				end
			end
			tlc_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = tlc_pkg::ST_IDLE;
				end
			end
			default: state_d = tlc_pkg::ST_IDLE;
		endcase
	end

	// scan decisions; rd_q holds the entry at idx_q during the walk
	always_comb begin
		count_nz   = (count_q != '0);
		hit        = count_nz && (rd_q.key == key_q);
		last       = !count_nz || ((tlc_pkg::COUNT_W'(idx_q) + tlc_pkg::COUNT_W'(1)) == count_q);
		cur_exp    = count_nz && entry_exp;
		finish     = (state_q == tlc_pkg::ST_SCAN) && (hit || last);
		append     = !hit && (count_q != tlc_pkg::COUNT_FULL);
		mem_we     = finish && (op_q == tlc_pkg::OP_FILL);
		// first expired entry of the walk, else the last slot
		if (exp_found_q) begin
			victim_idx = exp_idx_q;
		end else if (cur_exp) begin
			victim_idx = idx_q;
		end else begin
			victim_idx = tlc_pkg::LAST_IDX;
		end
		if (hit) begin
			wr_idx = idx_q;
		end else if (append) begin
			wr_idx = count_q[tlc_pkg::IDX_W-1:0];
		end else begin
			wr_idx = victim_idx;
		end
		wr_data.key     = key_q;
		wr_data.address = fill_q;
		wr_data.created = now_q;
		// read one entry ahead so the walk need not wait for the memory read
		if (state_q == tlc_pkg::ST_IDLE || idx_q == tlc_pkg::LAST_IDX) begin
			rd_idx = '0;
		end else begin
			rd_idx = idx_q + tlc_pkg::IDX_W'(1);
		end
	end

	// entries are written only at the last cycle of a walk, so no read in
	// flight can see a stale copy of the entry being replaced
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlc_pkg::ST_IDLE;
			ttl_q       <= tlc_pkg::TTL_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			exp_found_q <= 1'b0;
			exp_idx_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_valid && cfg_ready) begin
				ttl_q <= cfg_data;
			end
			if (accept) begin
				idx_q       <= '0;
				exp_found_q <= 1'b0;
			end else if (state_q == tlc_pkg::ST_SCAN && !finish) begin
				idx_q <= idx_q + tlc_pkg::IDX_W'(1);
				if (!exp_found_q && cur_exp) begin
					exp_found_q <= 1'b1;
					exp_idx_q   <= idx_q;
				end
			end
			if (mem_we && append) begin
				count_q <= count_q + tlc_pkg::COUNT_W'(1);
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			key_q  <= lookup_key;
			fill_q <= fill_address;
			now_q  <= now_seconds;
		end
		if (finish) begin
			if (op_q == tlc_pkg::OP_FILL) begin
				status_q  <= tlc_pkg::STAT_FILL;
				address_q <= fill_q;
				slot_q    <= tlc_pkg::to_slot(wr_idx);
			end else if (hit) begin
				status_q  <= entry_exp ? tlc_pkg::STAT_EXPIRED : tlc_pkg::STAT_FRESH;
				address_q <= rd_q.address;
				slot_q    <= tlc_pkg::to_slot(idx_q);
			end else begin
				status_q  <= tlc_pkg::STAT_MISS;
				address_q <= '0;
				slot_q    <= '0;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign stored_address = address_q;
	assign slot_index     = slot_q;

`include "assert_macros.svh"

	`ASSERT_AT(a_done_after_scan, clk, arst_n, done_q |-> $past(state_q == tlc_pkg::ST_SCAN), "result without a walk")
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > tlc_pkg::COUNT_FULL, "fill count beyond table size")
	`ASSERT_AT(a_count_by_fill, clk, arst_n, (count_q != $past(count_q)) |-> $past(mem_we), "fill count moved without a fill")
	`ASSERT_AT(a_miss_zero, clk, arst_n, (done_q && status_q == tlc_pkg::STAT_MISS) |-> (address_q == '0 && slot_q == '0), "miss with non-zero payload")

endmodule

`default_nettype wire
